[src/rpt_pkg.sv]
package rpt_pkg;

    // Element kinds.
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_END   = 3'd2;
    localparam logic [2:0] KIND_ANY   = 3'd3;
    localparam logic [2:0] KIND_LIT   = 3'd4;
    localparam logic [2:0] KIND_SET   = 3'd5;

    // Parser modes.
    localparam logic [2:0] MODE_START     = 3'd0;
    localparam logic [2:0] MODE_BASE      = 3'd1;
    localparam logic [2:0] MODE_END       = 3'd2;
    localparam logic [2:0] MODE_ESCAPE    = 3'd3;
    localparam logic [2:0] MODE_SET_OPEN  = 3'd4;
    localparam logic [2:0] MODE_SET       = 3'd5;
    localparam logic [2:0] MODE_SET_ESC   = 3'd6;
    localparam logic [2:0] MODE_SET_RANGE = 3'd7;

    // Repeat codes.
    localparam logic [1:0] REP_ONCE = 2'd0;
    localparam logic [1:0] REP_STAR = 2'd1;
    localparam logic [1:0] REP_PLUS = 2'd2;
    localparam logic [1:0] REP_OPT  = 2'd3;

    // Error codes.
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_BAD_CHAR    = 4'd1;
    localparam logic [3:0] ERR_START_POS   = 4'd2;
    localparam logic [3:0] ERR_BAD_REPEAT  = 4'd3;
    localparam logic [3:0] ERR_RANGE_FIRST = 4'd4;
    localparam logic [3:0] ERR_RANGE_OPEN  = 4'd5;
    localparam logic [3:0] ERR_RANGE_BAD   = 4'd6;
    localparam logic [3:0] ERR_AFTER_END   = 4'd7;
    localparam logic [3:0] ERR_UNCLOSED    = 4'd8;
    localparam logic [3:0] ERR_TRAIL_ESC   = 4'd9;

    // Special pattern characters.
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_CARET  = "^";
    localparam logic [7:0] CH_DOLLAR = "$";
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_QMARK  = "?";
    localparam logic [7:0] CH_LBRACK = "[";
    localparam logic [7:0] CH_RBRACK = "]";
    localparam logic [7:0] CH_DASH   = "-";
    localparam logic [7:0] CH_T      = "t";
    localparam logic [7:0] CH_N      = "n";
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_MIN    = 8'd32;
    localparam logic [7:0] CH_MAX    = 8'd126;

    localparam int DEFAULT_MAX_ELEMENTS = 1024;

    function automatic logic [7:0] map_escape(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_T) r = CH_TAB;
        else if (c == CH_N) r = CH_LF;
        return r;
    endfunction

endpackage

[src/regex_pattern_tokenizer.sv]
// Channel  | Direction | Signals                          | Content
// s_axis   | in        | tvalid tready tdata[7:0] tuser   | pattern character, end marker
// m_axis   | out       | tvalid tready tdata tlast        | element, error code, count
//
// One input transfer is taken per cycle; the character updates the parser registers
// and a result, when one is due, stands in the output register on the next cycle.
// A result is due when a new element begins while one is held, and on every end marker.
// s_axis_tready is low only while the output register is full and m_axis_tready is low.
// rst_n clears the parser to start mode with no held element and no error.
module regex_pattern_tokenizer #(
    parameter int MAX_ELEMENTS = rpt_pkg::DEFAULT_MAX_ELEMENTS,
    parameter int COUNT_W      = $clog2(MAX_ELEMENTS + 1),
    parameter int OUT_W        = ((145 + COUNT_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,  // ch
    input  logic             s_axis_tuser,  // func
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // kind[2:0], lit_char[9:3], negated[10], set_low[74:11], set_high[138:75],
    // repeat_res[140:139], error_code[144:141], element_count, zero fill
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast  // last
);

    localparam int FIELD_W = 145 + COUNT_W;

    logic [2:0]         mode_reg, mode_next;
    logic [127:0]       class_reg, class_next;
    logic               class_neg_reg, class_neg_next;
    logic [6:0]         range_start_reg, range_start_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [2:0]         pend_kind_reg, pend_kind_next;
    logic [6:0]         pend_char_reg, pend_char_next;
    logic               pend_neg_reg, pend_neg_next;
    logic [127:0]       pend_set_reg, pend_set_next;
    logic [1:0]         pend_rep_reg, pend_rep_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [3:0]         err_reg, err_next;

    logic               out_valid_reg;
    logic [FIELD_W-1:0] out_data_reg;
    logic               out_last_reg;

    logic               accept;
    logic               emit;
    logic [FIELD_W-1:0] emit_data;
    logic               emit_last;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - FIELD_W){1'b0}}, out_data_reg};
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        logic [7:0]   c;
        logic [7:0]   esc;
        logic [6:0]   rs;
        logic         do_set;
        logic         new_el;
        logic [2:0]   new_kind;
        logic [6:0]   new_char;
        logic [3:0]   fin_err;
        logic [127:0] fill;
        logic [140:0] held;

        c        = s_axis_tdata;
        esc      = rpt_pkg::map_escape(c);
        rs       = range_start_reg;
        do_set   = 1'b0;
        new_el   = 1'b0;
        new_kind = rpt_pkg::KIND_NONE;
        new_char = 7'd0;
        fin_err  = err_reg;

        mode_next        = mode_reg;
        class_next       = class_reg;
        class_neg_next   = class_neg_reg;
        range_start_next = range_start_reg;
        pend_valid_next  = pend_valid_reg;
        pend_kind_next   = pend_kind_reg;
        pend_char_next   = pend_char_reg;
        pend_neg_next    = pend_neg_reg;
        pend_set_next    = pend_set_reg;
        pend_rep_next    = pend_rep_reg;
        count_next       = count_reg;
        err_next         = err_reg;

        emit      = 1'b0;
        emit_last = 1'b0;
        held      = {pend_rep_reg, pend_set_reg, pend_neg_reg, pend_char_reg,
                     pend_kind_reg};
        emit_data = {{COUNT_W{1'b0}}, rpt_pkg::ERR_NONE, held};

        for (int i = 0; i < 128; i++)
        begin
            fill[i] = (8'(i) > {1'b0, range_start_reg}) && (8'(i) <= c);
        end

        if (s_axis_tuser)
        begin
            if (err_reg == rpt_pkg::ERR_NONE)
            begin
                if (mode_reg[2])
                    fin_err = rpt_pkg::ERR_UNCLOSED;
                else if (mode_reg == rpt_pkg::MODE_ESCAPE)
                    fin_err = rpt_pkg::ERR_TRAIL_ESC;
            end
            emit      = 1'b1;
            emit_last = 1'b1;
            if (fin_err != rpt_pkg::ERR_NONE)
                emit_data = {{COUNT_W{1'b0}}, fin_err, 141'd0};
            else if (pend_valid_reg)
                emit_data = {count_reg, rpt_pkg::ERR_NONE, held};
            else
                emit_data = {count_reg, rpt_pkg::ERR_NONE, 141'd0};
            // The end marker returns every parser register to its reset value.
            mode_next        = rpt_pkg::MODE_START;
            class_next       = '0;
            class_neg_next   = 1'b0;
            range_start_next = 7'd0;
            pend_valid_next  = 1'b0;
            pend_kind_next   = rpt_pkg::KIND_NONE;
            pend_char_next   = 7'd0;
            pend_neg_next    = 1'b0;
            pend_set_next    = '0;
            pend_rep_next    = rpt_pkg::REP_ONCE;
            count_next       = '0;
            err_next         = rpt_pkg::ERR_NONE;
        end
        else if (err_reg != rpt_pkg::ERR_NONE)
        begin
            // The first error is kept until the end marker.
        end
        else if (c < rpt_pkg::CH_MIN || c > rpt_pkg::CH_MAX)
        begin
            err_next = rpt_pkg::ERR_BAD_CHAR;
        end
        else
        begin
            unique case (mode_reg)
                rpt_pkg::MODE_START, rpt_pkg::MODE_BASE:
                begin
                    mode_next = rpt_pkg::MODE_BASE;
                    if (mode_reg == rpt_pkg::MODE_START && c == rpt_pkg::CH_CARET)
                    begin
                        new_el   = 1'b1;
                        new_kind = rpt_pkg::KIND_START;
                    end
                    else
                    begin
                        case (c)
                            rpt_pkg::CH_CARET: err_next = rpt_pkg::ERR_START_POS;
                            rpt_pkg::CH_DOLLAR:
                            begin
                                mode_next = rpt_pkg::MODE_END;
                                new_el    = 1'b1;
                                new_kind  = rpt_pkg::KIND_END;
                            end
                            rpt_pkg::CH_DOT:
                            begin
                                new_el   = 1'b1;
                                new_kind = rpt_pkg::KIND_ANY;
                            end
                            rpt_pkg::CH_STAR, rpt_pkg::CH_PLUS, rpt_pkg::CH_QMARK:
                            begin
                                if (!pend_valid_reg || pend_kind_reg == rpt_pkg::KIND_START
                                    || pend_kind_reg == rpt_pkg::KIND_END)
                                    err_next = rpt_pkg::ERR_BAD_REPEAT;
                                else if (c == rpt_pkg::CH_STAR)
                                    pend_rep_next = rpt_pkg::REP_STAR;
                                else if (c == rpt_pkg::CH_PLUS)
                                    pend_rep_next = rpt_pkg::REP_PLUS;
                                else
                                    pend_rep_next = rpt_pkg::REP_OPT;
                            end
                            rpt_pkg::CH_BSLASH: mode_next = rpt_pkg::MODE_ESCAPE;
                            rpt_pkg::CH_LBRACK:
                            begin
                                class_neg_next   = 1'b0;
                                class_next       = '0;
                                range_start_next = 7'd0;
                                mode_next        = rpt_pkg::MODE_SET_OPEN;
                            end
                            default:
                            begin
                                new_el   = 1'b1;
                                new_kind = rpt_pkg::KIND_LIT;
                                new_char = c[6:0];
                            end
                        endcase
                    end
                end
                rpt_pkg::MODE_ESCAPE:
                begin
                    mode_next = rpt_pkg::MODE_BASE;
                    new_el    = 1'b1;
                    new_kind  = rpt_pkg::KIND_LIT;
                    new_char  = esc[6:0];
                end
                rpt_pkg::MODE_SET_ESC:
                begin
                    range_start_next     = esc[6:0];
                    class_next[esc[6:0]] = 1'b1;
                    mode_next            = rpt_pkg::MODE_SET;
                end
                rpt_pkg::MODE_SET_RANGE:
                begin
                    if (c == rpt_pkg::CH_RBRACK)
                        err_next = rpt_pkg::ERR_RANGE_OPEN;
                    else if ({1'b0, rs} < c
                             && (({1'b0, rs} >= "a" && c <= "z")
                                 || ({1'b0, rs} >= "A" && c <= "Z")
                                 || ({1'b0, rs} >= "0" && c <= "9")))
                    begin
                        class_next = class_reg | fill;
                        mode_next  = rpt_pkg::MODE_SET;
                    end
                    else
                        err_next = rpt_pkg::ERR_RANGE_BAD;
                end
                rpt_pkg::MODE_SET_OPEN:
                begin
                    mode_next        = rpt_pkg::MODE_SET;
                    range_start_next = 7'd0;
                    rs               = 7'd0;
                    if (c == rpt_pkg::CH_CARET)
                        class_neg_next = 1'b1;
                    else
                        do_set = 1'b1;
                end
                rpt_pkg::MODE_SET:
                begin
                    do_set = 1'b1;
                end
                default:
                begin
                    err_next = rpt_pkg::ERR_AFTER_END;
                end
            endcase

            if (do_set)
            begin
                case (c)
                    rpt_pkg::CH_RBRACK:
                    begin
                        mode_next = rpt_pkg::MODE_BASE;
                        new_el    = 1'b1;
                        new_kind  = rpt_pkg::KIND_SET;
                    end
                    rpt_pkg::CH_BSLASH: mode_next = rpt_pkg::MODE_SET_ESC;
                    rpt_pkg::CH_DASH:
                    begin
                        if (rs == 7'd0)
                            err_next = rpt_pkg::ERR_RANGE_FIRST;
                        else
                            mode_next = rpt_pkg::MODE_SET_RANGE;
                    end
                    default:
                    begin
                        range_start_next   = c[6:0];
                        class_next[c[6:0]] = 1'b1;
                    end
                endcase
            end

            if (new_el)
            begin
                emit            = pend_valid_reg;
                pend_valid_next = 1'b1;
                pend_kind_next  = new_kind;
                pend_char_next  = new_char;
                pend_neg_next   = (new_kind == rpt_pkg::KIND_SET) ? class_neg_reg : 1'b0;
                pend_set_next   = (new_kind == rpt_pkg::KIND_SET) ? class_reg : '0;
                pend_rep_next   = rpt_pkg::REP_ONCE;
                if (count_reg < COUNT_W'(MAX_ELEMENTS))
                    count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= rpt_pkg::MODE_START;
            class_reg       <= '0;
            class_neg_reg   <= 1'b0;
            range_start_reg <= 7'd0;
            pend_valid_reg  <= 1'b0;
            pend_kind_reg   <= rpt_pkg::KIND_NONE;
            pend_char_reg   <= 7'd0;
            pend_neg_reg    <= 1'b0;
            pend_set_reg    <= '0;
            pend_rep_reg    <= rpt_pkg::REP_ONCE;
            count_reg       <= '0;
            err_reg         <= rpt_pkg::ERR_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg        <= mode_next;
                class_reg       <= class_next;
                class_neg_reg   <= class_neg_next;
                range_start_reg <= range_start_next;
                pend_valid_reg  <= pend_valid_next;
                pend_kind_reg   <= pend_kind_next;
                pend_char_reg   <= pend_char_next;
                pend_neg_reg    <= pend_neg_next;
                pend_set_reg    <= pend_set_next;
                pend_rep_reg    <= pend_rep_next;
                count_reg       <= count_next;
                err_reg         <= err_next;
            end
            if (accept && emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= emit_data;
            out_last_reg <= emit_last;
        end
    end

    // An end marker always leaves a final result in the output register.
    a_end_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tuser |=> m_axis_tvalid && m_axis_tlast)
        else $error("end marker did not produce a last result");

    // After an end marker the parser is back in start mode with nothing held.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tuser |=> mode_reg == rpt_pkg::MODE_START && !pend_valid_reg
            && count_reg == '0 && err_reg == rpt_pkg::ERR_NONE)
        else $error("parser state not cleared after end marker");

    // Errors and counts only appear on the final result.
    a_mid_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> out_data_reg[FIELD_W-1:141] == '0)
        else $error("non-final result carries an error or count");

    // Once an error is latched, characters leave it in place.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !s_axis_tuser && err_reg != rpt_pkg::ERR_NONE |=> $stable(err_reg))
        else $error("latched error changed before end marker");

    // A held result is never overwritten while it waits.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_data_reg))
        else $error("pending result lost under backpressure");

endmodule
